>>> rtl/ws2812_pulse_encoder_macros.svh
// Assertion macros shared by the pulse encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef WS2812_PULSE_ENCODER_MACROS_SVH
`define WS2812_PULSE_ENCODER_MACROS_SVH

// Checked while out of reset.
`define WPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define WPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ws2812pe_pkg.sv
// Types and constants of the WS2812 pulse encoder.
// No dependencies; imported by every module of the block.
package ws2812pe_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned TICK_W = 15;
  localparam int unsigned WORD_W = 3 * CHAN_W;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // index of the last data symbol and of the reset symbol
  localparam logic [CNT_W-1:0] LAST_DATA_SYM = 5'd23;
  localparam logic [CNT_W-1:0] RESET_SYM = 5'd24;

  localparam logic [CHAN_W-1:0] FULL_BRIGHTNESS = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS = 3'd5;

  // register reset values
  localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd255;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST = 15'd28;
  localparam logic [TICK_W-1:0] ONE_LOW_RST = 15'd24;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd14;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST = 15'd32;
  localparam logic [TICK_W-1:0] RESET_TICKS_RST = 15'd2000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic              first_level;
    logic [TICK_W-1:0] first_ticks;
    logic              second_level;
    logic [TICK_W-1:0] second_ticks;
    logic              symbol_last;
  } symbol_t;

  // scaled pixel in GRB order, handed to the serializer
  typedef struct packed {
    logic [WORD_W-1:0] grb;
    logic              last;
  } word_beat_t;

endpackage

>>> rtl/ws2812_pulse_encoder.sv
// WS2812 pulse encoder: pixel in, 24 bit symbols (+ reset symbol) out.
// A beat is held in the scale stage, then in the serializer shift register, then in
// the output symbol register. One symbol per cycle unless sym_ready stalls: 24 per
// pixel, plus the reset symbol for a pixel that ends a frame.
// Reset (rst, synchronous): pipeline emptied, registers back to defaults.
// Depends on ws2812pe_pkg, ws2812pe_scale and ws2812_pulse_encoder_macros.svh.
`include "ws2812_pulse_encoder_macros.svh"

module ws2812_pulse_encoder import ws2812pe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  // pixel beats
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pixel_t               pix,
  // symbol beats
  output logic                 sym_valid,
  input  logic                 sym_ready,
  output symbol_t              sym
);

  // configuration registers
  logic [CHAN_W-1:0] brightness;
  logic [TICK_W-1:0] one_high_ticks;
  logic [TICK_W-1:0] one_low_ticks;
  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] zero_low_ticks;
  logic [TICK_W-1:0] reset_ticks;

  // scaled pixel from the input stage
  logic       word_valid;
  logic       word_ready;
  word_beat_t word;

  // serializer state
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] shreg;
  logic              last_r;

  logic    adv;
  logic    fin;
  symbol_t sym_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= BRIGHTNESS_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      one_low_ticks   <= ONE_LOW_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
      zero_low_ticks  <= ZERO_LOW_RST;
      reset_ticks     <= RESET_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BRIGHTNESS:  brightness      <= cfg_data[CHAN_W-1:0];
        CFG_ONE_HIGH:    one_high_ticks  <= cfg_data;
        CFG_ONE_LOW:     one_low_ticks   <= cfg_data;
        CFG_ZERO_HIGH:   zero_high_ticks <= cfg_data;
        CFG_ZERO_LOW:    zero_low_ticks  <= cfg_data;
        CFG_RESET_TICKS: reset_ticks     <= cfg_data;
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Stage 1: scale and pack into GRB, held until the serializer takes it.
  ws2812pe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  // Stage 2: serializer. The output register moves when empty or drained.
  assign adv = !sym_valid || sym_ready;

  // Final symbol of the current pixel goes out this cycle: bit 23 for a
  // mid-frame pixel, the reset symbol for a frame-ending one.
  assign fin = busy && adv &&
               (((cnt == LAST_DATA_SYM) && !last_r) || (cnt == RESET_SYM));

  // Next pixel loads in the same cycle the current one finishes, so a waiting
  // pixel follows with no gap in the symbol stream.
  assign word_ready = !busy || fin;

  always_comb begin
    sym_next.second_level = 1'b0;
    if (cnt == RESET_SYM) begin
      sym_next.first_level  = 1'b0;
      sym_next.first_ticks  = reset_ticks;
      sym_next.second_ticks = '0;
      sym_next.symbol_last  = 1'b1;
    end else begin
      sym_next.first_level  = 1'b1;
      sym_next.first_ticks  = shreg[WORD_W-1] ? one_high_ticks : zero_high_ticks;
      sym_next.second_ticks = shreg[WORD_W-1] ? one_low_ticks : zero_low_ticks;
      sym_next.symbol_last  = (cnt == LAST_DATA_SYM) && !last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      sym_valid <= 1'b0;
    end else begin
      if (adv) begin
        sym_valid <= busy;
      end
      if (word_valid && word_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (fin) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else if (busy && adv) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // payload: MSB-first shift register and output symbol
  always_ff @(posedge clk) begin
    if (adv && busy) begin
      sym <= sym_next;
    end
    if (word_valid && word_ready) begin
      shreg  <= word.grb;
      last_r <= word.last;
    end else if (busy && adv) begin
      shreg <= {shreg[WORD_W-2:0], 1'b0};
    end
  end

  `WPE_ASSERT(a_reset_sym_at_end, busy && (cnt == RESET_SYM) |-> last_r, "reset sym mid-frame")
  `WPE_ASSERT(a_rst_sym_last, sym_valid && !sym.first_level |-> sym.symbol_last, "sym not last")
  `WPE_ASSERT(a_cnt_steps, busy && adv && !fin |=> busy && cnt == $past(cnt) + 1'b1, "cnt skipped")
  `WPE_ASSERT_ALWAYS(a_reset_empties, rst |=> !sym_valid && !busy && !word_valid, "pipe not empty")

endmodule

>>> rtl/ws2812pe_scale.sv
// Input stage: brightness scaling and GRB packing into a one-beat holding register.
// Depends on ws2812pe_pkg.
module ws2812pe_scale import ws2812pe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAN_W-1:0] brightness,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pixel_t            pix,
  output logic              word_valid,
  input  logic              word_ready,
  output word_beat_t        word
);

  word_beat_t word_next;

  function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                              input logic [CHAN_W-1:0] br);
    logic [2*CHAN_W-1:0] prod;
    prod = c * br;
    if (br == FULL_BRIGHTNESS) begin
      return c;
    end
    return prod[2*CHAN_W-1:CHAN_W];
  endfunction

  assign pix_ready = !word_valid || word_ready;

  always_comb begin
    word_next.grb  = {scale(pix.green, brightness), scale(pix.red, brightness),
                      scale(pix.blue, brightness)};
    word_next.last = pix.last_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (pix_ready) begin
      word_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      word <= word_next;
    end
  end

endmodule
